FILE: design/buddy_page_allocator_core_defines.svh
// ---------------------------------------------------------------------------
// buddy page allocator assertion macros
// ---------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, held off during reset
`define BPA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpa assertion failed");
// next-cycle implication, held off during reset
`define BPA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpa assertion failed");
`else
`define BPA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BPA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: design/bpa_pkg.sv
// ---------------------------------------------------------------------------
// bpa_pkg
// shared types and codes of the buddy page allocator
// ---------------------------------------------------------------------------
package bpa_pkg;

  localparam int FRAME_BITS_DEF = 16;
  localparam int TOP_ORDER_DEF  = 10;
  localparam int ORDER_W        = 4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_ORDER = 3'd1;
  localparam logic [2:0] ST_NO_MEMORY = 3'd2;
  localparam logic [2:0] ST_FRAME_0   = 3'd3;
  localparam logic [2:0] ST_MISALIGN  = 3'd4;

  typedef struct packed {
    logic               opcode;
    logic [ORDER_W-1:0] block_order;
    logic [15:0]        frame_number;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] granted_frame;
    logic [16:0] free_total;
  } rsp_t;

  typedef struct packed {
    logic               on;
    logic [ORDER_W-1:0] ord;
  } meta_t;

  typedef struct packed {
    logic next_we;
    logic prev_we;
    logic meta_we;
  } mem_ctl_t;

endpackage

FILE: design/bpa_store.sv
// ---------------------------------------------------------------------------
// bpa_store
// per-frame link and order memories with registered reads; the order
// memory is swept clear after reset
// ---------------------------------------------------------------------------
module bpa_store import bpa_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mem_ctl_t              ctl,
  input  logic [FRAME_BITS-1:0] next_addr,
  input  logic [FRAME_BITS:0]   next_wdata,
  output logic [FRAME_BITS:0]   next_rdata,
  input  logic [FRAME_BITS-1:0] prev_addr,
  input  logic [FRAME_BITS:0]   prev_wdata,
  output logic [FRAME_BITS:0]   prev_rdata,
  input  logic [FRAME_BITS-1:0] meta_addr,
  input  meta_t                 meta_wdata,
  output meta_t                 meta_rdata,
  output logic                  clr_busy
);

  localparam int DEPTH = 2 ** FRAME_BITS;

  logic [FRAME_BITS:0]   next_mem [0:DEPTH-1];
  logic [FRAME_BITS:0]   prev_mem [0:DEPTH-1];
  meta_t                 meta_mem [0:DEPTH-1];
  logic [FRAME_BITS-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == '1) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.next_we) begin
      next_mem[next_addr] <= next_wdata;
    end
    next_rdata <= next_mem[next_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.prev_we) begin
      prev_mem[prev_addr] <= prev_wdata;
    end
    prev_rdata <= prev_mem[prev_addr];
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      meta_mem[clr_idx] <= '0;
    end else if (ctl.meta_we) begin
      meta_mem[meta_addr] <= meta_wdata;
    end
    meta_rdata <= meta_mem[meta_addr];
  end

endmodule

FILE: design/bpa_seq.sv
// ---------------------------------------------------------------------------
// bpa_seq
// request sequencer: free list heads, page total, split and merge walks
// ---------------------------------------------------------------------------
`include "buddy_page_allocator_core_defines.svh"

module bpa_seq import bpa_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF,
  parameter int TOP_ORDER  = TOP_ORDER_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  res_valid,
  input  logic                  res_ready,
  output rsp_t                  res,
  output mem_ctl_t              ctl,
  output logic [FRAME_BITS-1:0] next_addr,
  output logic [FRAME_BITS:0]   next_wdata,
  input  logic [FRAME_BITS:0]   next_rdata,
  output logic [FRAME_BITS-1:0] prev_addr,
  output logic [FRAME_BITS:0]   prev_wdata,
  input  logic [FRAME_BITS:0]   prev_rdata,
  output logic [FRAME_BITS-1:0] meta_addr,
  output meta_t                 meta_wdata,
  input  meta_t                 meta_rdata,
  input  logic                  clr_busy
);

  localparam int FB = FRAME_BITS;
  localparam int LW = FRAME_BITS + 1;
  localparam int HW = $clog2(TOP_ORDER + 1);
  localparam logic [LW-1:0] NIL = {1'b1, {FB{1'b0}}};

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_A_HEAD   = 4'd2;
  localparam logic [3:0] S_A_LINK   = 4'd3;
  localparam logic [3:0] S_A_CLR    = 4'd4;
  localparam logic [3:0] S_SPLIT    = 4'd5;
  localparam logic [3:0] S_M_TEST   = 4'd6;
  localparam logic [3:0] S_M_CHECK  = 4'd7;
  localparam logic [3:0] S_M_CLR    = 4'd8;
  localparam logic [3:0] S_M_PUSH   = 4'd9;
  localparam logic [3:0] S_PUSH_FIX = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0]         state;
  req_t               req_r;
  logic [ORDER_W-1:0] cur;
  logic [FB-1:0]      blk;
  logic [FB-1:0]      bud;
  logic [FB-1:0]      pf;
  logic [LW-1:0]      h_r;
  logic [LW-1:0]      heads [0:TOP_ORDER];
  logic [LW-1:0]      total;

  logic               found_ok;
  logic [ORDER_W-1:0] found_idx;
  logic [HW-1:0]      hidx;
  logic [LW-1:0]      head_rd;
  logic [FB-1:0]      frame_w;
  logic [FB-1:0]      bud_c;
  logic [FB-1:0]      split_f;
  logic [ORDER_W-1:0] cur_m1;
  logic [LW-1:0]      one_sh;
  logic               merge_more;
  logic               merge_ok;
  logic               bad_order;
  logic               misalign;

  assign req_ready = (state == S_IDLE) && !clr_busy;
  assign res_valid = (state == S_DONE);

  assign frame_w    = FB'(req_r.frame_number);
  assign cur_m1     = cur - 4'd1;
  assign bud_c      = blk ^ (FB'(1) << cur);
  assign split_f    = blk + (FB'(1) << cur_m1);
  assign one_sh     = LW'(1) << req_r.block_order;
  assign bad_order  = req_r.block_order > 4'(TOP_ORDER);
  assign misalign   = (frame_w & ~({FB{1'b1}} << req_r.block_order)) != '0;
  assign merge_more = ({1'b0, cur} < 5'(TOP_ORDER)) && ({1'b0, cur} < 5'(FRAME_BITS - 1));
  assign merge_ok   = meta_rdata.on && (meta_rdata.ord == cur);
  assign hidx       = (state == S_SPLIT) ? cur_m1[HW-1:0] : cur[HW-1:0];
  assign head_rd    = heads[hidx];

  // lowest non-empty list at or above the requested order
  always_comb begin
    found_ok  = 1'b0;
    found_idx = '0;
    for (int k = TOP_ORDER; k >= 0; k--) begin
      if (4'(k) >= req_r.block_order && !heads[k][FB]) begin
        found_ok  = 1'b1;
        found_idx = 4'(k);
      end
    end
  end

  always_comb begin
    ctl        = '0;
    next_addr  = blk;
    prev_addr  = blk;
    meta_addr  = blk;
    next_wdata = NIL;
    prev_wdata = NIL;
    meta_wdata = '0;
    unique case (state)
      S_A_HEAD: begin
        next_addr = head_rd[FB-1:0];
        prev_addr = head_rd[FB-1:0];
        meta_addr = head_rd[FB-1:0];
      end
      S_A_LINK, S_M_CHECK: begin
        // unlink, neighbour half: prev gets next, next gets prev
        if (state == S_A_LINK || merge_ok) begin
          ctl.next_we = !prev_rdata[FB];
          next_addr   = prev_rdata[FB-1:0];
          next_wdata  = next_rdata;
          ctl.prev_we = !next_rdata[FB];
          prev_addr   = next_rdata[FB-1:0];
          prev_wdata  = prev_rdata;
        end
      end
      S_A_CLR: begin
        ctl            = '{next_we: 1'b1, prev_we: 1'b1, meta_we: 1'b1};
        meta_wdata.ord = req_r.block_order;
      end
      S_SPLIT: begin
        if (cur > req_r.block_order) begin
          ctl        = '{next_we: 1'b1, prev_we: 1'b1, meta_we: 1'b1};
          next_addr  = split_f;
          prev_addr  = split_f;
          meta_addr  = split_f;
          next_wdata = head_rd;
          meta_wdata = '{on: 1'b1, ord: cur_m1};
        end
      end
      S_M_TEST: begin
        next_addr = bud_c;
        prev_addr = bud_c;
        meta_addr = bud_c;
      end
      S_M_CLR: begin
        ctl            = '{next_we: 1'b1, prev_we: 1'b1, meta_we: 1'b1};
        next_addr      = bud;
        prev_addr      = bud;
        meta_addr      = bud;
        meta_wdata.ord = cur;
      end
      S_M_PUSH: begin
        ctl        = '{next_we: 1'b1, prev_we: 1'b1, meta_we: 1'b1};
        next_wdata = head_rd;
        meta_wdata = '{on: 1'b1, ord: cur};
      end
      S_PUSH_FIX: begin
        ctl.prev_we = !h_r[FB];
        prev_addr   = h_r[FB-1:0];
        prev_wdata  = {1'b0, pf};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      for (int k = 0; k <= TOP_ORDER; k++) begin
        heads[k] <= NIL;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            req_r <= req;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (bad_order) begin
            res   <= '{status: ST_BAD_ORDER, granted_frame: '0, free_total: 17'(total)};
            state <= S_DONE;
          end else if (req_r.opcode == OP_ALLOC) begin
            if (found_ok) begin
              cur   <= found_idx;
              state <= S_A_HEAD;
            end else begin
              res   <= '{status: ST_NO_MEMORY, granted_frame: '0, free_total: 17'(total)};
              state <= S_DONE;
            end
          end else if (frame_w == '0) begin
            res   <= '{status: ST_FRAME_0, granted_frame: '0, free_total: 17'(total)};
            state <= S_DONE;
          end else if (misalign) begin
            res   <= '{status: ST_MISALIGN, granted_frame: '0, free_total: 17'(total)};
            state <= S_DONE;
          end else begin
            blk   <= frame_w;
            cur   <= req_r.block_order;
            state <= S_M_TEST;
          end
        end
        S_A_HEAD: begin
          blk   <= head_rd[FB-1:0];
          state <= S_A_LINK;
        end
        S_A_LINK: begin
          if (prev_rdata[FB]) begin
            heads[hidx] <= next_rdata;
          end
          state <= S_A_CLR;
        end
        S_A_CLR: begin
          state <= S_SPLIT;
        end
        S_SPLIT: begin
          if (cur > req_r.block_order) begin
            h_r         <= head_rd;
            heads[hidx] <= {1'b0, split_f};
            pf          <= split_f;
            cur         <= cur_m1;
            state       <= S_PUSH_FIX;
          end else begin
            total <= total - one_sh;
            res   <= '{status: ST_OK, granted_frame: 16'(blk),
                       free_total: 17'(total - one_sh)};
            state <= S_DONE;
          end
        end
        S_M_TEST: begin
          bud <= bud_c;
          if (merge_more) begin
            state <= S_M_CHECK;
          end else begin
            state <= S_M_PUSH;
          end
        end
        S_M_CHECK: begin
          if (merge_ok) begin
            if (prev_rdata[FB]) begin
              heads[hidx] <= next_rdata;
            end
            state <= S_M_CLR;
          end else begin
            state <= S_M_PUSH;
          end
        end
        S_M_CLR: begin
          if (bud < blk) begin
            blk <= bud;
          end
          cur   <= cur + 4'd1;
          state <= S_M_TEST;
        end
        S_M_PUSH: begin
          h_r         <= head_rd;
          heads[hidx] <= {1'b0, blk};
          pf          <= blk;
          state       <= S_PUSH_FIX;
        end
        S_PUSH_FIX: begin
          if (req_r.opcode == OP_ALLOC) begin
            state <= S_SPLIT;
          end else begin
            total <= total + one_sh;
            res   <= '{status: ST_OK, granted_frame: '0,
                       free_total: 17'(total + one_sh)};
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BPA_ASSERT_IMP(a_split_floor, clk, rst, state == S_SPLIT, cur >= req_r.block_order)
  `BPA_ASSERT_IMP(a_buddy_one_bit, clk, rst, state == S_M_CLR, $onehot(bud ^ blk))
  `BPA_ASSERT_IMP(a_quiet_clear, clk, rst, clr_busy, !(ctl.next_we || ctl.prev_we || ctl.meta_we))
  `BPA_ASSERT_NXT(a_merge_step, clk, rst, state == S_M_CLR, state == S_M_TEST && cur == $past(cur) + 4'd1)
  `BPA_ASSERT_IMP(a_fail_no_grant, clk, rst, res_valid && res.status != ST_OK, res.granted_frame == '0)

endmodule

FILE: design/buddy_page_allocator_core.sv
// one request at a time, the next taken in the cycle after the result is registered;
// the split or merge walk over the link memories sets the rate
// reset clears list heads and total, then sweeps the order memory, one
// frame a cycle, over all 2^FRAME_BITS frames before the first request is taken
// ---------------------------------------------------------------------------
// buddy_page_allocator_core
// binary buddy page allocator with free lists in per-frame link memories
// ---------------------------------------------------------------------------
module buddy_page_allocator_core import bpa_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF,
  parameter int TOP_ORDER  = TOP_ORDER_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  mem_ctl_t              ctl;
  logic [FRAME_BITS-1:0] next_addr;
  logic [FRAME_BITS:0]   next_wdata;
  logic [FRAME_BITS:0]   next_rdata;
  logic [FRAME_BITS-1:0] prev_addr;
  logic [FRAME_BITS:0]   prev_wdata;
  logic [FRAME_BITS:0]   prev_rdata;
  logic [FRAME_BITS-1:0] meta_addr;
  meta_t                 meta_wdata;
  meta_t                 meta_rdata;
  logic                  clr_busy;
  logic                  res_valid;
  logic                  res_ready;
  rsp_t                  res;

  bpa_store #(.FRAME_BITS(FRAME_BITS)) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .next_addr  (next_addr),
    .next_wdata (next_wdata),
    .next_rdata (next_rdata),
    .prev_addr  (prev_addr),
    .prev_wdata (prev_wdata),
    .prev_rdata (prev_rdata),
    .meta_addr  (meta_addr),
    .meta_wdata (meta_wdata),
    .meta_rdata (meta_rdata),
    .clr_busy   (clr_busy)
  );

  bpa_seq #(.FRAME_BITS(FRAME_BITS), .TOP_ORDER(TOP_ORDER)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .ctl        (ctl),
    .next_addr  (next_addr),
    .next_wdata (next_wdata),
    .next_rdata (next_rdata),
    .prev_addr  (prev_addr),
    .prev_wdata (prev_wdata),
    .prev_rdata (prev_rdata),
    .meta_addr  (meta_addr),
    .meta_wdata (meta_wdata),
    .meta_rdata (meta_rdata),
    .clr_busy   (clr_busy)
  );

  // output register frees the sequencer while a result waits
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp <= res;
    end
  end

endmodule

FILE: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// random and directed requests against the buddy page allocator, with an
// in-bench free-list model predicting status, granted frame and free total
// ---------------------------------------------------------------------------
module tb_top;
  import bpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FBITS  = FRAME_BITS_DEF;
  localparam int TOPORD = TOP_ORDER_DEF;
  localparam int NFR    = 1 << FBITS;
  localparam logic [16:0] NIL = 17'(NFR);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  buddy_page_allocator_core dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // allocator mirror
  logic [16:0] nxt_lnk [NFR];
  logic [16:0] prv_lnk [NFR];
  logic [3:0]  blk_ord [NFR];
  bit          is_free [NFR];
  logic [16:0] heads [TOPORD+1];
  logic [16:0] pages_free;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  // blocks handed out, so frees are mostly well formed
  logic [15:0] held_frame[$];
  logic [3:0]  held_ord[$];
  int errors = 0;
  bit stim_done = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  function automatic void push_blk(input logic [15:0] f, input int o);
    logic [16:0] h;
    h = heads[o];
    prv_lnk[f] = NIL;
    nxt_lnk[f] = h;
    blk_ord[f] = 4'(o);
    is_free[f] = 1'b1;
    if (h < NIL) prv_lnk[h[15:0]] = {1'b0, f};
    heads[o] = {1'b0, f};
  endfunction

  function automatic void unlink_blk(input logic [15:0] f, input int o);
    logic [16:0] p, n;
    p = prv_lnk[f];
    n = nxt_lnk[f];
    if (p < NIL) nxt_lnk[p[15:0]] = n;
    else heads[o] = n;
    if (n < NIL) prv_lnk[n[15:0]] = p;
    prv_lnk[f] = NIL;
    nxt_lnk[f] = NIL;
    is_free[f] = 1'b0;
  endfunction

  function automatic rsp_t predict_alloc_result(input req_t r);
    rsp_t e;
    int cur, o;
    logic [15:0] blk, f, bud;
    e = '0;
    o = int'(r.block_order);
    f = r.frame_number;
    if (o > TOPORD) begin
      e.status = ST_BAD_ORDER;
    end else if (r.opcode == OP_ALLOC) begin
      cur = o;
      while (cur <= TOPORD && heads[cur] >= NIL) cur++;
      if (cur > TOPORD) begin
        e.status = ST_NO_MEMORY;
      end else begin
        blk = heads[cur][15:0];
        unlink_blk(blk, cur);
        while (cur > o) begin
          cur--;
          push_blk(blk + 16'(1 << cur), cur);
        end
        blk_ord[blk] = 4'(o);
        pages_free = pages_free - 17'(1 << o);
        e.status = ST_OK;
        e.granted_frame = blk;
      end
    end else if (f == 0) begin
      e.status = ST_FRAME_0;
    end else if ((f & 16'((1 << o) - 1)) != 0) begin
      e.status = ST_MISALIGN;
    end else begin
      cur = o;
      while (cur < TOPORD && cur < FBITS - 1) begin
        bud = f ^ 16'(1 << cur);
        if (!is_free[bud] || blk_ord[bud] != 4'(cur)) break;
        unlink_blk(bud, cur);
        if (bud < f) f = bud;
        cur++;
      end
      push_blk(f, cur);
      pages_free = pages_free + 17'(1 << o);
      e.status = ST_OK;
    end
    e.free_total = pages_free;
    return e;
  endfunction

  function automatic req_t mk(input logic op, input int o, input int f);
    req_t r;
    r.opcode = op;
    r.block_order = 4'(o);
    r.frame_number = 16'(f);
    return r;
  endfunction

  // sender: bursts and gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        expected_rsps.push_back(predict_alloc_result(req));
      end
      if (req_valid && !req_ready) begin
        // hold
      end else if (gap_left > 0) begin
        req_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          if ($urandom_range(0, 3) != 0) gap_left <= $urandom_range(0, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern that changes mode now and then
  logic [7:0] stall_pat = 8'hff;
  int pat_ph = 0;
  always @(posedge clk) begin
    rsp_t e;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          report("unexpected result", 32'(rsp), 0);
        end else begin
          e = expected_rsps.pop_front();
          if (rsp.status !== e.status) report("status", 32'(rsp.status), 32'(e.status));
          if (rsp.granted_frame !== e.granted_frame)
            report("granted_frame", 32'(rsp.granted_frame), 32'(e.granted_frame));
          if (rsp.free_total !== e.free_total)
            report("free_total", 32'(rsp.free_total), 32'(e.free_total));
        end
      end
      pat_ph <= (pat_ph + 1) % 8;
      if (pat_ph == 7 && $urandom_range(0, 9) == 0)
        stall_pat <= ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
      rsp_ready <= stall_pat[pat_ph];
    end
  end

  initial begin
    int o, f, k;
    for (int i = 0; i < NFR; i++) begin
      blk_ord[i] = '0;
      is_free[i] = 1'b0;
    end
    for (int i = 0; i <= TOPORD; i++) heads[i] = NIL;
    pages_free = '0;

    // directed: errors on an empty store, then seed and exercise
    pending_reqs.push_back(mk(OP_ALLOC, 0, 0));
    pending_reqs.push_back(mk(OP_ALLOC, 15, 16'hffff));
    pending_reqs.push_back(mk(OP_FREE, 11, 16'h0400));
    pending_reqs.push_back(mk(OP_FREE, 0, 0));
    pending_reqs.push_back(mk(OP_FREE, 10, 0));
    pending_reqs.push_back(mk(OP_FREE, 3, 16'h0004));
    pending_reqs.push_back(mk(OP_FREE, 10, 16'hfc00));
    pending_reqs.push_back(mk(OP_FREE, 10, 16'hf800));
    pending_reqs.push_back(mk(OP_FREE, 10, 16'h0400));
    pending_reqs.push_back(mk(OP_ALLOC, 0, 16'hffff));
    pending_reqs.push_back(mk(OP_ALLOC, 10, 0));
    pending_reqs.push_back(mk(OP_ALLOC, 5, 0));
    pending_reqs.push_back(mk(OP_FREE, 0, 16'hf800));
    pending_reqs.push_back(mk(OP_FREE, 5, 16'hf820));
    // double free
    pending_reqs.push_back(mk(OP_FREE, 5, 16'hf820));
    pending_reqs.push_back(mk(OP_ALLOC, 0, 0));
    pending_reqs.push_back(mk(OP_ALLOC, 10, 0));
    pending_reqs.push_back(mk(OP_ALLOC, 10, 0));
    pending_reqs.push_back(mk(OP_ALLOC, 10, 0));
    pending_reqs.push_back(mk(OP_ALLOC, 10, 0));
    pending_reqs.push_back(mk(OP_FREE, 15, 16'h8000));
    pending_reqs.push_back(mk(OP_FREE, 1, 16'hffff));

    // random: noise requests, seeding frees of aligned blocks, allocations, and frees of
    // previously granted blocks. granted frames are tracked here from a
    // shadow model so frees never touch never-written links.
    begin : seeded
      // shadow the directed stream to know what is held
      req_t r;
      rsp_t e;
      foreach (pending_reqs[i]) begin
        r = pending_reqs[i];
        e = predict_alloc_result(r);
        if (r.opcode == OP_ALLOC && e.status == ST_OK) begin
          held_frame.push_back(e.granted_frame);
          held_ord.push_back(r.block_order);
        end
      end
      for (int i = 0; i < 1500; i++) begin
        k = $urandom_range(0, 99);
        if (k < 8) begin
          // noise: any field values, not a well-formed free
          r = req_t'(21'($urandom));
          if (r.opcode == OP_FREE && r.block_order <= TOPORD && r.frame_number != 0 &&
              (r.frame_number & 16'((1 << r.block_order) - 1)) == 0)
            r.block_order = 4'($urandom_range(TOPORD + 1, 15));
        end else if (k < 20 || held_frame.size() == 0) begin
          o = $urandom_range(0, TOPORD);
          f = ($urandom_range(1, NFR - 1) >> o) << o;
          if (f == 0) f = 1 << o;
          r = mk(OP_FREE, o, f);
        end else if (k < 55) begin
          r = mk(OP_ALLOC, $urandom_range(0, 3) == 0 ? $urandom_range(0, TOPORD) :
                 $urandom_range(0, 3), $urandom);
        end else begin
          f = $urandom_range(0, held_frame.size() - 1);
          r = mk(OP_FREE, int'(held_ord[f]), int'(held_frame[f]));
          held_frame.delete(f);
          held_ord.delete(f);
        end
        e = predict_alloc_result(r);
        if (r.opcode == OP_ALLOC && e.status == ST_OK) begin
          held_frame.push_back(e.granted_frame);
          held_ord.push_back(r.block_order);
        end
        pending_reqs.push_back(r);
      end
    end

    // restore the mirror to reset state for the live run
    for (int i = 0; i < NFR; i++) begin
      blk_ord[i] = '0;
      is_free[i] = 1'b0;
    end
    for (int i = 0; i <= TOPORD; i++) heads[i] = NIL;
    pages_free = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (req_valid) @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #4ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

FILE: buddy_page_allocator_core.f
+incdir+design
design/bpa_pkg.sv
design/bpa_store.sv
design/bpa_seq.sv
design/buddy_page_allocator_core.sv
verif/tb_top.sv
